/* src/rsmp_pkg.sv */
// Package for the polyphase fractional resampler.
// Holds fixed field widths, register indexes, opcodes and the engine state type.
// No dependencies.
`default_nettype none

package rsmp_pkg;

  // Fixed-width fields
  localparam int TAP_W      = 16;   // tap coefficient, signed Q2.14
  localparam int TAP_FRAC   = 14;   // fraction bits of a tap
  localparam int FRAC_BITS  = 16;   // fraction bits of a position
  localparam int POS_W      = 24;   // position accumulator width
  localparam int INC_W      = 18;   // phase_increment, Q2.16
  localparam int INIT_W     = 20;   // initial_phase, Q4.16
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int MAX_RESULTS = 8;   // outputs one sample may cause

  localparam logic [INC_W-1:0] MIN_INC   = INC_W'(8192);
  localparam logic [INC_W-1:0] INC_RESET = INC_W'(65536);
  localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1) << FRAC_BITS;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_PHASE = 1'b1;

  // Input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TAP    = 1'b1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MAC,
    B_EMIT
  } back_state_t;

  // Handshake between the queue and its neighbors
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

/* src/rsmp_if.sv */
// Channel interfaces of the polyphase fractional resampler.
// Depends on rsmp_pkg for the tap width.
`default_nettype none

interface rsmp_in_if
  import rsmp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int NUM_TAPS     = 8,
  parameter int PHASE_STEPS  = 128
);
  localparam int TPH_W = $clog2(PHASE_STEPS + 1);
  localparam int TIX_W = $clog2(NUM_TAPS);

  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic signed [SAMPLE_WIDTH-1:0] sample_re;
  logic signed [SAMPLE_WIDTH-1:0] sample_im;
  logic        [TPH_W-1:0]        tap_phase;
  logic        [TIX_W-1:0]        tap_index;
  logic signed [TAP_W-1:0]        tap_value;

  modport source (output valid, opcode, sample_re, sample_im, tap_phase, tap_index,
                  tap_value, input ready);
  modport sink   (input valid, opcode, sample_re, sample_im, tap_phase, tap_index,
                  tap_value, output ready);
endinterface

interface rsmp_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_re;
  logic signed [SAMPLE_WIDTH-1:0] out_im;
  logic                           last_in_run;

  modport source (output valid, out_re, out_im, last_in_run, input ready);
  modport sink   (input valid, out_re, out_im, last_in_run, output ready);
endinterface

`default_nettype wire

/* src/rsmp_front.sv */
// Front end: accepts input items, drops out-of-range tap writes and packs
// the rest into queue entries. Depends on rsmp_pkg and rsmp_if.
`default_nettype none

module rsmp_front
  import rsmp_pkg::*;
#(
  parameter int NUM_TAPS     = 8,
  parameter int PHASE_STEPS  = 128,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ADDR_W       = 11,
  parameter int ENTRY_W      = 60
) (
  rsmp_in_if.sink            in_ch,
  input  q_status_t          q_stat,
  output logic               q_push,
  output logic [ENTRY_W-1:0] q_entry
);

  logic              is_tap;
  logic              tap_ok;
  logic [ADDR_W-1:0] tap_addr;

  assign is_tap   = (in_ch.opcode == OP_TAP);
  assign tap_ok   = (int'(in_ch.tap_phase) <= PHASE_STEPS) &&
                    (int'(in_ch.tap_index) < NUM_TAPS);
  assign tap_addr = ADDR_W'(in_ch.tap_phase) * ADDR_W'(NUM_TAPS) + ADDR_W'(in_ch.tap_index);

  // Bad tap writes are taken and dropped here
  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full && (!is_tap || tap_ok);
  assign q_entry     = {is_tap, tap_addr, in_ch.tap_value, in_ch.sample_re, in_ch.sample_im};

endmodule

`default_nettype wire

/* src/rsmp_fifo.sv */
// Short queue between front end and filter engine.
// Depends on rsmp_pkg for the status type.
`default_nettype none

module rsmp_fifo
  import rsmp_pkg::*;
#(
  parameter int DATA_W = 60,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_status_t         stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* src/rsmp_back.sv */
// Filter engine: tap memory, sample window, output position and one shared
// complex multiply-accumulate walking a tap row. Depends on rsmp_pkg, rsmp_if.
`default_nettype none

module rsmp_back
  import rsmp_pkg::*;
#(
  parameter int NUM_TAPS     = 8,
  parameter int PHASE_STEPS  = 128,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ADDR_W       = 11,
  parameter int ENTRY_W      = 60
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  q_status_t             q_stat,
  input  logic [ENTRY_W-1:0]    q_entry,
  output logic                  q_pop,
  rsmp_out_if.source            out_ch
);

  localparam int SW        = SAMPLE_WIDTH;
  localparam int TAP_WORDS = (PHASE_STEPS + 1) * NUM_TAPS;
  localparam int PH_W      = $clog2(PHASE_STEPS + 1);
  localparam int K_W       = $clog2(NUM_TAPS + 1);
  localparam int RK_W      = $clog2(NUM_TAPS);
  localparam int N_W       = $clog2(MAX_RESULTS + 1);
  localparam int PROD_W    = SW + TAP_W;
  localparam int ACC_W     = PROD_W + $clog2(NUM_TAPS) + 1;
  localparam int Q_W       = ACC_W - TAP_FRAC;
  localparam int RP_W      = FRAC_BITS + PH_W;

  localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_LO = Q_W'(-(64'sd1 <<< (SW - 1)));

  function automatic logic [SW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [Q_W-1:0]   q;
    t = acc + ACC_W'(1 << (TAP_FRAC - 1));
    q = t[ACC_W-1:TAP_FRAC];
    if (q > Q_HI) begin
      q = Q_HI;
    end else if (q < Q_LO) begin
      q = Q_LO;
    end
    return q[SW-1:0];
  endfunction

  // Queue entry fields
  logic                    e_is_tap;
  logic [ADDR_W-1:0]       e_addr;
  logic signed [TAP_W-1:0] e_tap;
  logic signed [SW-1:0]    e_re, e_im;

  assign e_is_tap = q_entry[ENTRY_W-1];
  assign e_addr   = q_entry[ENTRY_W-2 -: ADDR_W];
  assign e_tap    = q_entry[2*SW +: TAP_W];
  assign e_re     = q_entry[SW +: SW];
  assign e_im     = q_entry[0 +: SW];

  back_state_t             state_r, state_nxt;
  logic [INC_W-1:0]        inc_r;
  logic [INC_W-1:0]        inc_eff;
  logic [POS_W-1:0]        pos_r, pos_nxt, pos_adv;
  logic [K_W-1:0]          seen_r, seen_nxt;
  logic [K_W-1:0]          k_r, k_nxt;
  logic [N_W-1:0]          n_r, n_nxt;
  logic signed [SW-1:0]    win_re_r [NUM_TAPS];
  logic signed [SW-1:0]    win_im_r [NUM_TAPS];
  logic [TAP_W-1:0]        tap_mem [TAP_WORDS];
  logic signed [TAP_W-1:0] tap_q_r;
  logic                    rd_v_r, mul_v_r;
  logic [RK_W-1:0]         rd_k_r;
  logic signed [PROD_W-1:0] prod_re_r, prod_im_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic                    out_valid_r;
  logic [SW-1:0]           out_re_r, out_im_r;
  logic                    out_last_r;
  logic                    restart, shift_en, mem_we, issue, acc_clr, out_load, out_last;

  // Phase row from the fraction: round half to even, clamp to the last row
  logic [RP_W-1:0]   rp_prod;
  logic [PH_W-1:0]   rp_q;
  logic [FRAC_BITS-1:0] rp_r;
  logic              rp_up;
  logic [PH_W:0]     rp_sum;
  logic [PH_W-1:0]   row;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    rp_prod = RP_W'(pos_r[FRAC_BITS-1:0]) * RP_W'(PHASE_STEPS);
    rp_q    = rp_prod[RP_W-1:FRAC_BITS];
    rp_r    = rp_prod[FRAC_BITS-1:0];
    rp_up   = (rp_r > POS_ONE[FRAC_BITS:1]) ||
              ((rp_r == POS_ONE[FRAC_BITS:1]) && rp_q[0]);
    rp_sum  = {1'b0, rp_q} + (PH_W + 1)'(rp_up);
    row     = (rp_sum > (PH_W + 1)'(PHASE_STEPS)) ? PH_W'(PHASE_STEPS) : rp_sum[PH_W-1:0];
    rd_addr = ADDR_W'(row) * ADDR_W'(NUM_TAPS) + ADDR_W'(k_r[RK_W-1:0]);
  end

  assign inc_eff = (inc_r < MIN_INC) ? MIN_INC : inc_r;
  assign pos_adv = pos_r + POS_W'(inc_eff);
  assign restart = cfg_we && (cfg_idx == REG_INIT_PHASE);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    q_pop     = 1'b0;
    shift_en  = 1'b0;
    mem_we    = 1'b0;
    issue     = 1'b0;
    acc_clr   = 1'b0;
    out_load  = 1'b0;
    out_last  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (e_is_tap) begin
            mem_we = 1'b1;
          end else begin
            shift_en = 1'b1;
            if (seen_r < K_W'(NUM_TAPS)) begin
              seen_nxt = seen_r + 1'b1;
            end else if (pos_r >= POS_ONE) begin
              pos_nxt = pos_r - POS_ONE;
            end
            if ((seen_nxt == K_W'(NUM_TAPS)) && (pos_nxt < POS_ONE)) begin
              state_nxt = B_MAC;
              k_nxt     = '0;
              n_nxt     = '0;
              acc_clr   = 1'b1;
            end
          end
        end
      end
      B_MAC: begin
        if (k_r < K_W'(NUM_TAPS)) begin
          issue = 1'b1;
          k_nxt = k_r + 1'b1;
        end else if (!rd_v_r && !mul_v_r) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          n_nxt    = n_r + 1'b1;
          pos_nxt  = pos_adv;
          out_last = (n_nxt == N_W'(MAX_RESULTS)) || (pos_adv >= POS_ONE);
          if (out_last) begin
            state_nxt = B_IDLE;
          end else begin
            state_nxt = B_MAC;
            k_nxt     = '0;
            acc_clr   = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    if (restart) begin
      pos_nxt  = POS_W'(cfg_data);
      seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      inc_r   <= INC_RESET;
      pos_r   <= '0;
      seen_r  <= '0;
      k_r     <= '0;
      n_r     <= '0;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
      if (cfg_we && (cfg_idx == REG_PHASE_INC)) begin
        inc_r <= cfg_data[INC_W-1:0];
      end
    end
  end

  // Sample window, oldest first
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        win_re_r[i] <= '0;
        win_im_r[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < NUM_TAPS - 1; i++) begin
        win_re_r[i] <= win_re_r[i+1];
        win_im_r[i] <= win_im_r[i+1];
      end
      win_re_r[NUM_TAPS-1] <= e_re;
      win_im_r[NUM_TAPS-1] <= e_im;
    end
  end

  // Tap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tap_mem[e_addr] <= e_tap;
    end
    tap_q_r <= tap_mem[rd_addr];
  end

  // Multiply then accumulate
  always_ff @(posedge clk) begin
    rd_k_r    <= k_r[RK_W-1:0];
    prod_re_r <= win_re_r[rd_k_r] * tap_q_r;
    prod_im_r <= win_im_r[rd_k_r] * tap_q_r;
    if (acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (mul_v_r) begin
      acc_re_r <= acc_re_r + ACC_W'(prod_re_r);
      acc_im_r <= acc_im_r + ACC_W'(prod_im_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r   <= round_sat(acc_re_r);
      out_im_r   <= round_sat(acc_im_r);
      out_last_r <= out_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_re      = out_re_r;
  assign out_ch.out_im      = out_im_r;
  assign out_ch.last_in_run = out_last_r;

endmodule

`default_nettype wire

/* src/polyphase_fractional_resampler.sv */
// Top level of the polyphase fractional resampler (8-tap interpolator).
// Depends on rsmp_pkg, rsmp_if, rsmp_front, rsmp_fifo and rsmp_back.
//
//   Channel   Direction  Handshake          Carries
//   in_ch     in         valid/ready        opcode, sample_re/im, tap_phase/index/value
//   out_ch    out        valid/ready        out_re, out_im, last_in_run
//   cfg_*     in         cfg_we, no wait    phase_increment (0), initial_phase (1)
//
// Each output walks the tap row through the single read port of the tap memory
// into one shared complex multiply-accumulate, waits while the read and multiply
// stages drain, and then rounds into the output register.
// Reset is synchronous (rst_n low): empty queue, cleared window, position zero,
// increment 1.0; the tap memory holds nothing until written.
// The queue lets the front keep accepting while the engine or out_ch stalls.
`default_nettype none

module polyphase_fractional_resampler
  import rsmp_pkg::*;
#(
  parameter int NUM_TAPS     = 8,
  parameter int PHASE_STEPS  = 128,
  parameter int SAMPLE_WIDTH = 16,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rsmp_in_if.sink               in_ch,
  rsmp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Tap memory address and queue entry layout: {is_tap, addr, tap, re, im}
  localparam int ADDR_W  = $clog2((PHASE_STEPS + 1) * NUM_TAPS);
  localparam int ENTRY_W = 1 + ADDR_W + TAP_W + 2 * SAMPLE_WIDTH;

  q_status_t          q_stat;
  logic               q_push, q_pop;
  logic [ENTRY_W-1:0] q_in, q_out;

  // Classify and pack; drop tap writes outside the table
  rsmp_front #(
    .NUM_TAPS     (NUM_TAPS),
    .PHASE_STEPS  (PHASE_STEPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ADDR_W       (ADDR_W),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // Hold items in order between front and engine
  rsmp_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Apply tap writes, advance the window and emit each transfer on out_ch
  rsmp_back #(
    .NUM_TAPS     (NUM_TAPS),
    .PHASE_STEPS  (PHASE_STEPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ADDR_W       (ADDR_W),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .q_entry  (q_out),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
